@@ hdl/sparse_tile_framebuffer_top_defines.svh @@
// Assertion macros shared by the sparse tile framebuffer RTL.
// Depends on clk and arst_n being visible at the point of use.
`ifndef SPARSE_TILE_FRAMEBUFFER_TOP_DEFINES_SVH
`define SPARSE_TILE_FRAMEBUFFER_TOP_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define STFB_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("stfb assertion failed");

// antecedent implies consequent in the next cycle
`define STFB_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("stfb assertion failed");

`endif

@@ hdl/stfb_pkg.sv @@
// Shared types and codes for the sparse tile framebuffer.
// No dependencies.
package stfb_pkg;

	typedef struct packed {
		logic [1:0] operation;
		logic [9:0] x;
		logic [9:0] y;
		logic       color;
		logic [7:0] byte_column;
	} stfb_item_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] data_byte;
		logic       row_active;
	} stfb_result_t;

	localparam logic [1:0] OP_DRAW  = 2'd0;
	localparam logic [1:0] OP_SCAN  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_IGNORED = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;

	localparam logic [1:0] CODE_WHITE = 2'd2;
	localparam logic [1:0] CODE_BLACK = 2'd1;

	localparam int QDEPTH = 4;

endpackage

@@ hdl/sparse_tile_framebuffer_top.sv @@
// Top level of the sparse tile framebuffer: front, job queue and back.
// Depends on stfb_pkg, stfb_front, stfb_fifo, stfb_back.
//
// One command is taken when start is high and busy low; each command gives
// exactly one result on result, marked by a one-cycle done strobe that cannot
// be held off. The front splits coordinates in three pipeline stages and feeds
// a four-entry queue. The back does one command at a time through memories
// with one write port and one registered read port. Clear and ignored commands
// are answered from idle; a scan read does map read, owner check, byte read;
// a draw into an allocated tile does map read, owner check and byte
// read-modify-write; a draw that allocates a tile zeroes the new buffer,
// writing the pixel byte on the way. After reset busy stays high while the
// tile map is cleared.
module sparse_tile_framebuffer_top import stfb_pkg::*; #(
	parameter int SCREEN_WIDTH = 800,
	parameter int SCREEN_HEIGHT = 600,
	parameter int TILE_WIDTH = 20,
	parameter int TILE_HEIGHT = 20,
	parameter int POOL_SIZE = 40
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  stfb_item_t   item,
	output logic         busy,
	output logic         done,
	output stfb_result_t result
);

	localparam int TILES_X = SCREEN_WIDTH / TILE_WIDTH;
	localparam int TILES_Y = SCREEN_HEIGHT / TILE_HEIGHT;
	localparam int TILES = TILES_X * TILES_Y;
	localparam int TB = (TILE_WIDTH + 3) / 4;
	localparam int BB = TILE_HEIGHT * TB;
	localparam int SW = (TILES > 1) ? $clog2(TILES) : 1;
	localparam int TYW = (TILES_Y > 1) ? $clog2(TILES_Y) : 1;
	localparam int OFFW = (BB > 1) ? $clog2(BB) : 1;
	localparam int JW = 2 + 1 + SW + TYW + OFFW + 2 + 1;

	logic          back_init, job_push, job_pop, job_empty;
	logic [JW-1:0] job_in, job_out;

	stfb_front #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT),
		.TILE_WIDTH    (TILE_WIDTH),
		.TILE_HEIGHT   (TILE_HEIGHT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.item      (item),
		.back_init (back_init),
		.job_pop   (job_pop),
		.busy      (busy),
		.job_push  (job_push),
		.job       (job_in)
	);

	stfb_fifo #(.W(JW), .DEPTH(QDEPTH)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.din    (job_in),
		.pop    (job_pop),
		.dout   (job_out),
		.empty  (job_empty)
	);

	stfb_back #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT),
		.TILE_WIDTH    (TILE_WIDTH),
		.TILE_HEIGHT   (TILE_HEIGHT),
		.POOL_SIZE     (POOL_SIZE)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (job_out),
		.job_empty (job_empty),
		.job_pop   (job_pop),
		.init      (back_init),
		.done      (done),
		.result    (result)
	);

endmodule

@@ hdl/stfb_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module stfb_ram #(
	parameter int W = 8,
	parameter int D = 16,
	localparam int AW = (D > 1) ? $clog2(D) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem_q [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ hdl/stfb_fifo.sv @@
// Short job queue between the front and back parts.
// No dependencies.
module stfb_fifo #(
	parameter int W = 8,
	parameter int DEPTH = 4,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] din,
	input  logic         pop,
	output logic [W-1:0] dout,
	output logic         empty
);

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wptr_q, rptr_q;
	logic [CW-1:0] count_q;

	assign dout  = mem_q[rptr_q];
	assign empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			count_q <= count_q + CW'(push) - CW'(pop);
		end
	end

endmodule

@@ hdl/stfb_front.sv @@
// Front part: accepts items, splits coordinates into tile and offset, checks range.
// Depends on stfb_pkg.
module stfb_front import stfb_pkg::*; #(
	parameter int SCREEN_WIDTH = 800,
	parameter int SCREEN_HEIGHT = 600,
	parameter int TILE_WIDTH = 20,
	parameter int TILE_HEIGHT = 20,
	localparam int TILES_X = SCREEN_WIDTH / TILE_WIDTH,
	localparam int TILES_Y = SCREEN_HEIGHT / TILE_HEIGHT,
	localparam int TILES = TILES_X * TILES_Y,
	localparam int TB = (TILE_WIDTH + 3) / 4,
	localparam int BB = TILE_HEIGHT * TB,
	localparam int SW = (TILES > 1) ? $clog2(TILES) : 1,
	localparam int TYW = (TILES_Y > 1) ? $clog2(TILES_Y) : 1,
	localparam int OFFW = (BB > 1) ? $clog2(BB) : 1,
	localparam int JW = 2 + 1 + SW + TYW + OFFW + 2 + 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  stfb_item_t    item,
	input  logic          back_init,
	input  logic          job_pop,
	output logic          busy,
	output logic          job_push,
	output logic [JW-1:0] job
);

	typedef struct packed {
		logic [1:0]      op;
		logic            bad;
		logic [SW-1:0]   slot;
		logic [TYW-1:0]  ty;
		logic [OFFW-1:0] off;
		logic [1:0]      dxlo;
		logic            color;
	} job_t;

	localparam int XS = 10 + $clog2(TILE_WIDTH);
	localparam int YS = 10 + $clog2(TILE_HEIGHT);
	localparam int CS = 8 + $clog2(TB);
	localparam longint XM = ((64'sd1 <<< XS) + TILE_WIDTH - 1) / TILE_WIDTH;
	localparam longint YM = ((64'sd1 <<< YS) + TILE_HEIGHT - 1) / TILE_HEIGHT;
	localparam longint CM = ((64'sd1 <<< CS) + TB - 1) / TB;
	localparam int XPW = 10 + XS + 1;
	localparam int YPW = 10 + YS + 1;
	localparam int CPW = 8 + CS + 1;
	localparam int DYW = (TILE_HEIGHT > 1) ? $clog2(TILE_HEIGHT) : 1;
	localparam int CXW = (TB > 1) ? $clog2(TB) : 1;
	localparam int CRW = $clog2(QDEPTH + 1);

	logic           accept;
	logic [CRW-1:0] credits_q;

	logic [XPW-1:0] xp;
	logic [YPW-1:0] yp;
	logic [CPW-1:0] cp;

	logic        v_s1, v_s2, v_s3;
	logic [1:0]  op_s1;
	logic [9:0]  x_s1, y_s1, tx_s1, ty_s1;
	logic [7:0]  col_s1, tc_s1;
	logic        color_s1;

	logic            is_draw, is_scan, in_range;
	logic [9:0]      dx, txs;
	logic [19:0]     slot_full;
	logic [15:0]     dy_full, db_full;

	logic [1:0]      op_s2;
	logic            bad_s2, color_s2;
	logic [SW-1:0]   slot_s2;
	logic [TYW-1:0]  ty_s2;
	logic [DYW-1:0]  dy_s2;
	logic [CXW-1:0]  cx_s2;
	logic [1:0]      dxlo_s2;

	job_t job_s3;

	assign accept = start && !busy;
	assign busy   = back_init || (credits_q == CRW'(QDEPTH));

	assign xp = XPW'(item.x) * XPW'(XM);
	assign yp = YPW'(item.y) * YPW'(YM);
	assign cp = CPW'(item.byte_column) * CPW'(CM);

	assign is_draw  = (op_s1 == OP_DRAW);
	assign is_scan  = (op_s1 == OP_SCAN);
	assign txs      = is_scan ? {2'b00, tc_s1} : tx_s1;
	assign in_range = ({1'b0, ty_s1} < 11'(TILES_Y)) && ({1'b0, txs} < 11'(TILES_X));
	assign dx       = 10'(16'(x_s1) - 16'(tx_s1) * 16'(TILE_WIDTH));
	assign dy_full  = 16'(y_s1) - 16'(ty_s1) * 16'(TILE_HEIGHT);
	assign db_full  = 16'(col_s1) - 16'(tc_s1) * 16'(TB);
	assign slot_full = 20'(ty_s1) * 20'(TILES_X) + 20'(txs);

	assign job_push = v_s3;
	assign job      = job_s3;

	always_ff @(posedge clk) begin
		op_s1    <= item.operation;
		x_s1     <= item.x;
		y_s1     <= item.y;
		col_s1   <= item.byte_column;
		color_s1 <= item.color;
		tx_s1    <= xp[XS +: 10];
		ty_s1    <= yp[YS +: 10];
		tc_s1    <= cp[CS +: 8];

		op_s2    <= op_s1;
		bad_s2   <= (op_s1 == OP_CLEAR) ? 1'b0 : !((is_draw || is_scan) && in_range);
		color_s2 <= color_s1;
		slot_s2  <= SW'(slot_full);
		ty_s2    <= TYW'(ty_s1);
		dy_s2    <= DYW'(dy_full);
		cx_s2    <= is_scan ? CXW'(db_full) : CXW'(dx >> 2);
		dxlo_s2  <= dx[1:0];

		job_s3.op    <= op_s2;
		job_s3.bad   <= bad_s2;
		job_s3.slot  <= slot_s2;
		job_s3.ty    <= ty_s2;
		job_s3.off   <= OFFW'(16'(dy_s2) * 16'(TB) + 16'(cx_s2));
		job_s3.dxlo  <= dxlo_s2;
		job_s3.color <= color_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			credits_q <= '0;
		end else begin
			v_s1      <= accept;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			credits_q <= credits_q + CRW'(accept) - CRW'(job_pop);
		end
	end

endmodule

@@ hdl/stfb_back.sv @@
// Back part: tile map lookup, buffer allocation and zeroing, pixel update, scan read.
// Depends on stfb_pkg, stfb_ram and the assertion macro header.
`include "sparse_tile_framebuffer_top_defines.svh"

module stfb_back import stfb_pkg::*; #(
	parameter int SCREEN_WIDTH = 800,
	parameter int SCREEN_HEIGHT = 600,
	parameter int TILE_WIDTH = 20,
	parameter int TILE_HEIGHT = 20,
	parameter int POOL_SIZE = 40,
	localparam int TILES_X = SCREEN_WIDTH / TILE_WIDTH,
	localparam int TILES_Y = SCREEN_HEIGHT / TILE_HEIGHT,
	localparam int TILES = TILES_X * TILES_Y,
	localparam int TB = (TILE_WIDTH + 3) / 4,
	localparam int BB = TILE_HEIGHT * TB,
	localparam int SW = (TILES > 1) ? $clog2(TILES) : 1,
	localparam int TYW = (TILES_Y > 1) ? $clog2(TILES_Y) : 1,
	localparam int OFFW = (BB > 1) ? $clog2(BB) : 1,
	localparam int JW = 2 + 1 + SW + TYW + OFFW + 2 + 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [JW-1:0] job,
	input  logic          job_empty,
	output logic          job_pop,
	output logic          init,
	output logic          done,
	output stfb_result_t  result
);

	typedef struct packed {
		logic [1:0]      op;
		logic            bad;
		logic [SW-1:0]   slot;
		logic [TYW-1:0]  ty;
		logic [OFFW-1:0] off;
		logic [1:0]      dxlo;
		logic            color;
	} job_t;

	localparam int IW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
	localparam int NW = $clog2(POOL_SIZE + 1);
	localparam int BAW = (POOL_SIZE * BB > 1) ? $clog2(POOL_SIZE * BB) : 1;
	localparam int OWW = TYW + SW;
	localparam int CNW = $clog2(((TILES > BB) ? TILES : BB) + 1);

	localparam logic [2:0] S_INIT  = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_MAP   = 3'd2;
	localparam logic [2:0] S_OWN   = 3'd3;
	localparam logic [2:0] S_SCAN2 = 3'd4;
	localparam logic [2:0] S_WR    = 3'd5;
	localparam logic [2:0] S_ZERO  = 3'd6;

	job_t head, j_q;
	assign head = job;

	logic [2:0]     state_q;
	logic [CNW-1:0] cnt_q;
	logic [NW-1:0]  nf_q;
	logic [IW-1:0]  idx_q, ridx_q;
	logic [BAW-1:0] base_hit_q, base_new_q;
	logic           tvalid_q;
	logic           done_q;
	stfb_result_t   res_q;

	logic            tm_we;
	logic [SW-1:0]   tm_waddr;
	logic [IW-1:0]   tm_wdata, tm_rdata;
	logic            rm_we;
	logic [TYW-1:0]  rm_waddr;
	logic [IW-1:0]   rm_wdata, rm_rdata;
	logic            own_we;
	logic [IW-1:0]   own_raddr;
	logic [OWW-1:0]  own_rdata;
	logic            buf_we;
	logic [BAW-1:0]  buf_waddr, buf_raddr;
	logic [7:0]      buf_wdata, buf_rdata;

	logic       tv, rv, pool_full;
	logic [1:0] code;
	logic [2:0] sh;
	logic [7:0] cbyte, cmask;

	assign done   = done_q;
	assign result = res_q;
	assign init   = (state_q == S_INIT);

	assign tv = ({{(NW-IW){1'b0}}, idx_q} < nf_q) && (own_rdata[SW-1:0] == j_q.slot);
	assign rv = ({{(NW-IW){1'b0}}, ridx_q} < nf_q) && (own_rdata[OWW-1:SW] == j_q.ty);
	assign pool_full = (nf_q >= NW'(POOL_SIZE));
	assign code  = j_q.color ? CODE_WHITE : CODE_BLACK;
	assign sh    = {2'd3 - j_q.dxlo, 1'b0};
	assign cbyte = {6'b0, code} << sh;
	assign cmask = 8'h03 << sh;

	assign job_pop   = (state_q == S_IDLE) && !job_empty;
	assign own_raddr = (state_q == S_MAP) ? tm_rdata : ridx_q;
	assign buf_raddr = base_hit_q + BAW'(j_q.off);

	always_comb begin
		tm_we     = 1'b0;
		tm_waddr  = j_q.slot;
		tm_wdata  = IW'(nf_q);
		rm_we     = 1'b0;
		rm_waddr  = j_q.ty;
		rm_wdata  = IW'(nf_q);
		own_we    = 1'b0;
		buf_we    = 1'b0;
		buf_waddr = base_hit_q + BAW'(j_q.off);
		buf_wdata = (buf_rdata & ~cmask) | cbyte;
		case (state_q)
			S_INIT: begin
				tm_we    = 1'b1;
				tm_waddr = SW'(cnt_q);
				tm_wdata = '0;
				rm_we    = (cnt_q < CNW'(TILES_Y));
				rm_waddr = TYW'(cnt_q);
				rm_wdata = '0;
			end
			S_OWN: begin
				if (j_q.op == OP_DRAW && !tv && !pool_full) begin
					tm_we  = 1'b1;
					rm_we  = 1'b1;
					own_we = 1'b1;
				end
			end
			S_WR: begin
				buf_we = 1'b1;
			end
			S_ZERO: begin
				buf_we    = 1'b1;
				buf_waddr = base_new_q + BAW'(cnt_q);
				buf_wdata = (cnt_q == CNW'(j_q.off)) ? cbyte : 8'h00;
			end
			default: ;
		endcase
	end

	stfb_ram #(.W(IW), .D(TILES)) u_tile_map (
		.clk   (clk),
		.we    (tm_we),
		.waddr (tm_waddr),
		.wdata (tm_wdata),
		.raddr (head.slot),
		.rdata (tm_rdata)
	);

	stfb_ram #(.W(IW), .D(TILES_Y)) u_row_map (
		.clk   (clk),
		.we    (rm_we),
		.waddr (rm_waddr),
		.wdata (rm_wdata),
		.raddr (head.ty),
		.rdata (rm_rdata)
	);

	stfb_ram #(.W(OWW), .D(POOL_SIZE)) u_owner (
		.clk   (clk),
		.we    (own_we),
		.waddr (IW'(nf_q)),
		.wdata ({j_q.ty, j_q.slot}),
		.raddr (own_raddr),
		.rdata (own_rdata)
	);

	stfb_ram #(.W(8), .D(POOL_SIZE * BB)) u_buffers (
		.clk   (clk),
		.we    (buf_we),
		.waddr (buf_waddr),
		.wdata (buf_wdata),
		.raddr (buf_raddr),
		.rdata (buf_rdata)
	);

	always_ff @(posedge clk) begin
		if (job_pop) begin
			j_q <= head;
		end
		if (state_q == S_MAP) begin
			idx_q      <= tm_rdata;
			ridx_q     <= rm_rdata;
			base_hit_q <= BAW'(BAW'(tm_rdata) * BAW'(BB));
			base_new_q <= BAW'(BAW'(nf_q) * BAW'(BB));
		end
		if (state_q == S_OWN) begin
			tvalid_q <= tv;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			cnt_q   <= '0;
			nf_q    <= '0;
			done_q  <= 1'b0;
			res_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_INIT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNW'(TILES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (!job_empty) begin
						if (head.op == OP_CLEAR) begin
							nf_q   <= '0;
							done_q <= 1'b1;
							res_q  <= '{ST_DONE, 8'h00, 1'b0};
						end else if (head.bad) begin
							done_q <= 1'b1;
							res_q  <= '{ST_IGNORED, 8'h00, 1'b0};
						end else begin
							state_q <= S_MAP;
						end
					end
				end
				S_MAP: begin
					state_q <= S_OWN;
				end
				S_OWN: begin
					cnt_q <= '0;
					if (j_q.op == OP_SCAN) begin
						state_q <= S_SCAN2;
					end else if (tv) begin
						state_q <= S_WR;
					end else if (pool_full) begin
						done_q  <= 1'b1;
						res_q   <= '{ST_FULL, 8'h00, 1'b0};
						state_q <= S_IDLE;
					end else begin
						nf_q    <= nf_q + 1'b1;
						state_q <= S_ZERO;
					end
				end
				S_SCAN2: begin
					done_q  <= 1'b1;
					res_q   <= '{ST_DONE, tvalid_q ? buf_rdata : 8'h00, rv};
					state_q <= S_IDLE;
				end
				S_WR: begin
					done_q  <= 1'b1;
					res_q   <= '{ST_DONE, 8'h00, 1'b0};
					state_q <= S_IDLE;
				end
				S_ZERO: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNW'(BB - 1)) begin
						done_q  <= 1'b1;
						res_q   <= '{ST_DONE, 8'h00, 1'b0};
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`STFB_ASSERT_NOW(a_pool_count, 1'b1, nf_q <= NW'(POOL_SIZE))
	`STFB_ASSERT_NOW(a_done_idle, done_q, state_q == S_IDLE)
	`STFB_ASSERT_NOW(a_zero_bound, state_q == S_ZERO, cnt_q < CNW'(BB))
	`STFB_ASSERT_NEXT(a_alloc_step, own_we, nf_q == $past(nf_q) + 1'b1)

endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench for sparse_tile_framebuffer_top: draws, scan reads and clears.
// Depends on stfb_pkg and the framebuffer RTL; a scoreboard class predicts each result word.
module tb_top;
	import stfb_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SW = 800;
	localparam int SH = 600;
	localparam int TW = 20;
	localparam int TH = 20;
	localparam int POOL = 40;
	localparam int TX = SW / TW;
	localparam int TY = SH / TH;
	localparam int TBYTES = (TW + 3) / 4;
	localparam int BBYTES = TH * TBYTES;
	localparam int LIMIT = 3000000;
	localparam int ITEM_BITS = $bits(stfb_item_t);

	class fb_scoreboard;
		int unsigned tile_owner[TX*TY];
		int unsigned next_buf;
		logic [7:0] buf_mem[POOL*BBYTES];
		bit row_used[TY];
		stfb_result_t pending[$];
		int errors;

		function void free_tiles();
			foreach (tile_owner[i]) tile_owner[i] = 0;
			foreach (row_used[i]) row_used[i] = 0;
			next_buf = 0;
		endfunction

		function void note_item(stfb_item_t it);
			stfb_result_t r;
			int unsigned tx, ty, dx, dy, slot, b, pos, sh;
			r = '0;
			if (it.operation == OP_DRAW) begin
				tx = it.x / TW; ty = it.y / TH; dx = it.x % TW; dy = it.y % TH;
				if (tx >= TX || ty >= TY) begin
					r.status = ST_IGNORED;
				end else begin
					slot = ty * TX + tx;
					r.status = ST_DONE;
					if (tile_owner[slot] == 0) begin
						if (next_buf >= POOL) begin
							r.status = ST_FULL;
						end else begin
							b = next_buf;
							tile_owner[slot] = b + 1;
							next_buf++;
							row_used[ty] = 1;
							for (int k = 0; k < BBYTES; k++) buf_mem[b*BBYTES+k] = 0;
						end
					end else begin
						b = tile_owner[slot] - 1;
					end
					if (r.status == ST_DONE) begin
						pos = b * BBYTES + dy * TBYTES + dx / 4;
						sh = 6 - 2 * (dx % 4);
						buf_mem[pos] &= ~(8'd3 << sh);
						buf_mem[pos] |= 8'(it.color ? CODE_WHITE : CODE_BLACK) << sh;
					end
				end
			end else if (it.operation == OP_SCAN) begin
				ty = it.y / TH; dy = it.y % TH;
				tx = it.byte_column / TBYTES;
				if (ty >= TY || tx >= TX) begin
					r.status = ST_IGNORED;
				end else begin
					r.row_active = row_used[ty];
					slot = ty * TX + tx;
					if (tile_owner[slot] != 0)
						r.data_byte = buf_mem[(tile_owner[slot]-1)*BBYTES + dy*TBYTES
							+ it.byte_column % TBYTES];
				end
			end else if (it.operation == OP_CLEAR) begin
				free_tiles();
			end else begin
				r.status = ST_IGNORED;
			end
			pending.push_back(r);
		endfunction

		function void check_result(stfb_result_t got);
			stfb_result_t exp;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result word %h", got);
				return;
			end
			exp = pending.pop_front();
			if (got.status !== exp.status || got.data_byte !== exp.data_byte ||
					got.row_active !== exp.row_active) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: exp st=%0d data=%h act=%0d got st=%0d data=%h act=%0d",
						exp.status, exp.data_byte, exp.row_active,
						got.status, got.data_byte, got.row_active);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	stfb_item_t item = '0;
	logic busy, done;
	stfb_result_t result;
	fb_scoreboard sb = new();
	int idle_pct = 0;
	int cycles = 0;

	sparse_tile_framebuffer_top dut (
		.clk(clk), .arst_n(arst_n), .start(start), .item(item),
		.busy(busy), .done(done), .result(result)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	always @(posedge clk) begin
		if (arst_n && done) sb.check_result(result);
		cycles++;
		if (cycles > LIMIT) begin
			$display("** sparse_tile_framebuffer_top: FAILED **");
			$finish;
		end
	end

	// start stays high into the next word unless the sender idles
	task automatic send_word(stfb_item_t it);
		while ($urandom_range(99) < idle_pct) begin
			start <= 0;
			@(posedge clk);
		end
		start <= 1;
		item <= it;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note_item(it);
	endtask

	function automatic stfb_item_t mk(logic [1:0] op, int x, int y, bit c, int col);
		stfb_item_t it;
		it.operation = op; it.x = 10'(x); it.y = 10'(y); it.color = c;
		it.byte_column = 8'(col);
		return it;
	endfunction

	function automatic stfb_item_t rand_word();
		stfb_item_t it;
		int sel;
		it = ITEM_BITS'($urandom);
		sel = $urandom_range(99);
		if (sel < 60) begin
			it.operation = OP_DRAW;
			if (sel < 50) begin
				// mostly stay inside the first seven tile columns to reuse buffers
				it.x = 10'($urandom_range(6) * TW + $urandom_range(TW-1));
				it.y = 10'($urandom_range(TY-1) * TH + $urandom_range(TH-1));
			end
		end else if (sel < 92) begin
			it.operation = OP_SCAN;
			if (sel < 85) begin
				it.y = 10'($urandom_range(SH-1));
				it.byte_column = 8'($urandom_range(7 * TBYTES));
			end
		end else if (sel < 96) begin
			it.operation = OP_CLEAR;
		end else begin
			it.operation = 2'd3;
		end
		return it;
	endfunction

	initial begin
		int ph;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		send_word(mk(OP_SCAN, 0, 0, 0, 0));
		send_word(mk(OP_DRAW, 0, 0, 1, 0));
		send_word(mk(OP_DRAW, 1, 0, 0, 0));
		send_word(mk(OP_DRAW, 3, 0, 1, 0));
		send_word(mk(OP_DRAW, SW-1, SH-1, 0, 0));
		send_word(mk(OP_DRAW, SW, 0, 1, 0));
		send_word(mk(OP_DRAW, 0, SH, 1, 0));
		send_word(mk(OP_DRAW, 1023, 1023, 1, 0));
		send_word(mk(OP_SCAN, 0, 0, 0, 0));
		send_word(mk(OP_SCAN, 0, SH-1, 0, TX*TBYTES-1));
		send_word(mk(OP_SCAN, 0, SH, 0, 0));
		send_word(mk(OP_SCAN, 0, 0, 0, TX*TBYTES));
		send_word(mk(OP_SCAN, 1023, 1023, 1, 255));
		send_word(mk(2'd3, 1023, 1023, 1, 255));
		// exhaust the pool, then draw into further tiles that find it full
		for (int t = 0; t <= POOL; t++)
			send_word(mk(OP_DRAW, (t % TX) * TW + 19, (t / TX) * TH + 19, 1, 0));
		send_word(mk(OP_SCAN, 0, 19, 0, 4));
		send_word(mk(OP_CLEAR, 0, 0, 0, 0));
		send_word(mk(OP_SCAN, 0, 19, 0, 4));
		for (int i = 0; i < 1200; i++) begin
			ph = (i / 100) % 4;
			idle_pct = (ph == 1 || ph == 2) ? 64 : (ph == 3 ? 15 : 0);
			send_word(rand_word());
		end
		start <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (sb.errors == 0)
			$display("** sparse_tile_framebuffer_top: PASSED **");
		else
			$display("** sparse_tile_framebuffer_top: FAILED **");
		$finish;
	end
endmodule
